[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/dvaf_pkg.sv]
// shared constants and types for the decal vertex alpha fade block
// no dependencies
package dvaf_pkg;

  localparam int COORD_WIDTH_DEF     = 24;
  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int SCALE_W             = 24;
  localparam int Q_BITS              = 16;
  localparam logic [Q_BITS:0] Q_ONE  = {1'b1, {Q_BITS{1'b0}}};
  localparam int CFG_ADDR_W          = 6;
  localparam int CFG_DATA_W          = 64;

  localparam logic [2:0] REG_CAM_X   = 3'd0;
  localparam logic [2:0] REG_CAM_Y   = 3'd1;
  localparam logic [2:0] REG_CAM_Z   = 3'd2;
  localparam logic [2:0] REG_SCALE   = 3'd3;
  localparam logic [2:0] REG_BIAS    = 3'd4;
  localparam logic [2:0] REG_BOTTOM  = 3'd5;
  localparam logic [2:0] REG_TOP     = 3'd6;
  localparam logic [2:0] REG_DIFFUSE = 3'd7;

  typedef struct packed {
    logic b_zero;
    logic b_one;
    logic t_zero;
    logic t_one;
  } fade_flags_t;

endpackage

[rtl/decal_vertex_alpha_fade.sv]
// stage order: magnitudes, squares, sum, root, product, intensity, divider, alpha products, output register
// throughput: one word per cycle while the skid word is free; the root and divider pipelines retire one bit a stage
// a stalled output holds in a skid word, the pipeline stops only when that is full
// reset: rst_n synchronous active low, clears valid bits and loads register defaults
// depends on dvaf_pkg, dvaf_isqrt, dvaf_fade_div, dvaf_out_slice
module decal_vertex_alpha_fade #(
  parameter int COORD_WIDTH     = dvaf_pkg::COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS = dvaf_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // vertex_x, vertex_y, vertex_z, zero pad
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // red, green, blue, alpha
  output logic [31:0] out_tdata,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [dvaf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dvaf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dvaf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic cfg_pready
);
  import dvaf_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int DSHIFT = (W > 30) ? (W - 30) : 0;
  localparam int MW     = W + 1 - DSHIFT;
  localparam int SW     = 2 * MW + 2;
  localparam int DW     = SW / 2;
  localparam int PFRAC  = 20 + COORD_FRAC_BITS - DSHIFT;
  localparam int IFRAC  = (PFRAC > 20) ? PFRAC : 20;
  localparam int SHD    = IFRAC - PFRAC;
  localparam int SHB    = IFRAC - 20;
  localparam int PW     = DW + 1 + SCALE_W;
  localparam int AW     = ((PW + SHD > SCALE_W + SHB) ? PW + SHD : SCALE_W + SHB) + 1;
  localparam int NW     = W + 1;
  localparam int IW     = Q_BITS + 1;

  // configuration registers
  logic signed [W-1:0]       cam_x_r, cam_y_r, cam_z_r;
  logic signed [SCALE_W-1:0] scale_r, bias_r;
  logic [2*W-1:0]            bottom_r, top_r;
  logic [31:0]               diffuse_r;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      cam_z_r   <= '0;
      scale_r   <= '0;
      bias_r    <= SCALE_W'(1 << 20);
      bottom_r  <= {1'b1, {(W-1){1'b0}}, 1'b1, {(W-1){1'b0}}};
      top_r     <= {1'b0, {(W-1){1'b1}}, 1'b0, {(W-1){1'b1}}};
      diffuse_r <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CAM_X:   cam_x_r   <= cfg_pwdata[W-1:0];
        REG_CAM_Y:   cam_y_r   <= cfg_pwdata[W-1:0];
        REG_CAM_Z:   cam_z_r   <= cfg_pwdata[W-1:0];
        REG_SCALE:   scale_r   <= cfg_pwdata[SCALE_W-1:0];
        REG_BIAS:    bias_r    <= cfg_pwdata[SCALE_W-1:0];
        REG_BOTTOM:  bottom_r  <= cfg_pwdata[2*W-1:0];
        REG_TOP:     top_r     <= cfg_pwdata[2*W-1:0];
        REG_DIFFUSE: diffuse_r <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CAM_X:   cfg_prdata = CFG_DATA_W'(unsigned'(cam_x_r));
      REG_CAM_Y:   cfg_prdata = CFG_DATA_W'(unsigned'(cam_y_r));
      REG_CAM_Z:   cfg_prdata = CFG_DATA_W'(unsigned'(cam_z_r));
      REG_SCALE:   cfg_prdata = CFG_DATA_W'(unsigned'(scale_r));
      REG_BIAS:    cfg_prdata = CFG_DATA_W'(unsigned'(bias_r));
      REG_BOTTOM:  cfg_prdata = CFG_DATA_W'(bottom_r);
      REG_TOP:     cfg_prdata = CFG_DATA_W'(top_r);
      REG_DIFFUSE: cfg_prdata = CFG_DATA_W'(diffuse_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // pipeline enable
  logic en;
  assign in_tready = en;

  typedef struct packed {
    logic [NW-1:0] bnum;
    logic [NW-1:0] bden;
    logic [NW-1:0] tnum;
    logic [NW-1:0] tden;
    fade_flags_t   flags;
  } fade_side_t;

  typedef struct packed {
    logic [IW-1:0] inten;
    fade_flags_t   flags;
  } div_side_t;

  // stage a: magnitudes and band tests
  logic signed [W-1:0] vx, vy, vz;
  logic signed [W-1:0] bmin, bmax, tmin, tmax;
  logic [MW-1:0]       mag [3];
  fade_side_t          fs_a;

  assign vx   = in_tdata[W-1:0];
  assign vy   = in_tdata[2*W-1:W];
  assign vz   = in_tdata[3*W-1:2*W];
  assign bmin = bottom_r[2*W-1:W];
  assign bmax = bottom_r[W-1:0];
  assign tmin = top_r[2*W-1:W];
  assign tmax = top_r[W-1:0];

  for (genvar i = 0; i < 3; i++) begin : g_mag
    logic signed [W:0] c, v, d;
    logic [W:0]        m;
    always_comb begin
      c = (i == 0) ? (W+1)'(cam_x_r) : (i == 1) ? (W+1)'(cam_y_r) : (W+1)'(cam_z_r);
      v = (i == 0) ? (W+1)'(vx) : (i == 1) ? (W+1)'(vy) : (W+1)'(vz);
      d = c - v;
      m = d[W] ? unsigned'(-d) : unsigned'(d);
      mag[i] = MW'(m >> DSHIFT);
    end
  end

  always_comb begin
    fs_a.bnum         = NW'((NW)'(vz) - (NW)'(bmin));
    fs_a.bden         = NW'((NW)'(bmax) - (NW)'(bmin));
    fs_a.tnum         = NW'((NW)'(tmax) - (NW)'(vz));
    fs_a.tden         = NW'((NW)'(tmax) - (NW)'(tmin));
    fs_a.flags.b_zero = vz <= bmin;
    fs_a.flags.b_one  = vz >= bmax;
    fs_a.flags.t_zero = vz >= tmax;
    fs_a.flags.t_one  = vz <= tmin;
  end

  logic          a_v_r;
  logic [MW-1:0] a_mag_r [3];
  fade_side_t    a_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r  <= mag;
      a_side_r <= fs_a;
    end
  end

  // stage b: squares
  logic            b_v_r;
  logic [2*MW-1:0] b_sq_r [3];
  fade_side_t      b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_sq_r[i] <= a_mag_r[i] * a_mag_r[i];
      end
      b_side_r <= a_side_r;
    end
  end

  // stage c: sum of squares
  logic          c_v_r;
  logic [SW-1:0] c_sum_r;
  fade_side_t    c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sum_r  <= SW'(b_sq_r[0]) + SW'(b_sq_r[1]) + SW'(b_sq_r[2]);
      c_side_r <= b_side_r;
    end
  end

  // distance
  logic          s_v;
  logic [DW-1:0] s_root;
  fade_side_t    s_side;

  dvaf_isqrt #(
    .RAD_W  (SW),
    .SIDE_W ($bits(fade_side_t))
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (c_v_r),
    .in_rad   (c_sum_r),
    .in_side  (c_side_r),
    .out_v    (s_v),
    .out_root (s_root),
    .out_side (s_side)
  );

  // intensity: product then bias and clamp
  logic                 d1_v_r;
  logic signed [PW-1:0] d1_prod_r;
  fade_side_t           d1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_prod_r <= PW'(signed'({1'b0, s_root}) * scale_r);
      d1_side_r <= s_side;
    end
  end

  logic signed [AW-1:0] acc;
  logic [IW-1:0]        inten;

  always_comb begin
    acc = (AW'(d1_prod_r) <<< SHD) + (AW'(bias_r) <<< SHB);
    if (acc[AW-1] || acc == '0) begin
      inten = '0;
    end else if (|acc[AW-2:IFRAC]) begin
      inten = Q_ONE;
    end else begin
      inten = {1'b0, acc[IFRAC-1 -: Q_BITS]};
    end
  end

  logic          d2_v_r;
  logic [IW-1:0] d2_inten_r;
  fade_side_t    d2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v_r <= 1'b0;
    end else if (en) begin
      d2_v_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_inten_r <= inten;
      d2_side_r  <= d1_side_r;
    end
  end

  // fade ramps
  logic [1:0][NW-1:0]     dv_num, dv_den;
  div_side_t              dv_side_in, dv_side;
  logic                   dv_v;
  logic [1:0][Q_BITS-1:0] dv_q;

  assign dv_num           = {d2_side_r.tnum, d2_side_r.bnum};
  assign dv_den           = {d2_side_r.tden, d2_side_r.bden};
  assign dv_side_in.inten = d2_inten_r;
  assign dv_side_in.flags = d2_side_r.flags;

  dvaf_fade_div #(
    .NUM_W  (NW),
    .SIDE_W ($bits(div_side_t))
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (d2_v_r),
    .in_num   (dv_num),
    .in_den   (dv_den),
    .in_side  (dv_side_in),
    .out_v    (dv_v),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // alpha products
  logic [IW-1:0] bf, tf;

  always_comb begin
    if (dv_side.flags.b_zero) begin
      bf = '0;
    end else if (dv_side.flags.b_one) begin
      bf = Q_ONE;
    end else begin
      bf = {1'b0, dv_q[0]};
    end
    if (dv_side.flags.t_zero) begin
      tf = '0;
    end else if (dv_side.flags.t_one) begin
      tf = Q_ONE;
    end else begin
      tf = {1'b0, dv_q[1]};
    end
  end

  logic            m1_v_r;
  logic [2*IW-1:0] m1_p_r;
  logic [IW-1:0]   m1_tf_r;
  logic            m2_v_r;
  logic [3*IW-1:0] m2_p_r;
  logic            m3_v_r;
  logic [7:0]      m3_alpha_r;
  logic [3*IW+7:0] p3;

  assign p3 = m2_p_r * diffuse_r[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= dv_v;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p_r     <= dv_side.inten * bf;
      m1_tf_r    <= tf;
      m2_p_r     <= m1_p_r * m1_tf_r;
      m3_alpha_r <= p3[3*Q_BITS+7 -: 8];
    end
  end

  dvaf_out_slice #(
    .DATA_W (32)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (m3_v_r),
    .up_data    ({m3_alpha_r, diffuse_r[15:8], diffuse_r[23:16], diffuse_r[31:24]}),
    .up_ready   (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/dvaf_isqrt.sv]
// pipelined integer square root, one root bit per stage
// depends on nothing; side bits travel with each word
module dvaf_isqrt #(
  parameter int RAD_W  = 52,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_v,
  output logic [RAD_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]    out_side
);
  localparam int N   = RAD_W / 2;
  localparam int REM = N + 3;

  logic              v_r    [N];
  logic [RAD_W-1:0]  rad_r  [N];
  logic [REM-1:0]    rem_r  [N];
  logic [N-1:0]      root_r [N];
  logic [SIDE_W-1:0] side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic              v_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM-1:0]    rem_in;
    logic [N-1:0]      root_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM-1:0]    rem_sh;
    logic [REM-1:0]    trial;
    logic              ge;
    logic [REM-1:0]    rem_nxt;
    logic [N-1:0]      root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_v;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      rem_sh   = {rem_in[REM-3:0], rad_in[RAD_W-1 -: 2]};
      trial    = {1'b0, root_in, 2'b01};
      ge       = rem_sh >= trial;
      rem_nxt  = ge ? rem_sh - trial : rem_sh;
      root_nxt = {root_in[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_v    = v_r[N-1];
  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

[rtl/dvaf_fade_div.sv]
// pipelined two-lane restoring divider, one quotient bit per stage
// depends on dvaf_pkg for the quotient width
module dvaf_fade_div #(
  parameter int NUM_W  = 25,
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [1:0][NUM_W-1:0]      in_num,
  input  logic [1:0][NUM_W-1:0]      in_den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_v,
  output logic [1:0][dvaf_pkg::Q_BITS-1:0] out_q,
  output logic [SIDE_W-1:0]          out_side
);
  import dvaf_pkg::*;

  logic                  v_r    [Q_BITS];
  logic [1:0][NUM_W-1:0] rem_r  [Q_BITS];
  logic [1:0][NUM_W-1:0] den_r  [Q_BITS];
  logic [1:0][Q_BITS-1:0] q_r   [Q_BITS];
  logic [SIDE_W-1:0]     side_r [Q_BITS];

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    logic                   v_in;
    logic [1:0][NUM_W-1:0]  rem_in;
    logic [1:0][NUM_W-1:0]  den_in;
    logic [1:0][Q_BITS-1:0] q_in;
    logic [SIDE_W-1:0]      side_in;
    logic [1:0][NUM_W-1:0]  rem_nxt;
    logic [1:0][Q_BITS-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [NUM_W:0] r2;
      logic           ge;
      always_comb begin
        r2          = {rem_in[l], 1'b0};
        ge          = r2 >= {1'b0, den_in[l]};
        rem_nxt[l]  = ge ? NUM_W'(r2 - {1'b0, den_in[l]}) : NUM_W'(r2);
        q_nxt[l]    = {q_in[l][Q_BITS-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        q_r[k]    <= q_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_v    = v_r[Q_BITS-1];
  assign out_q    = q_r[Q_BITS-1];
  assign out_side = side_r[Q_BITS-1];

endmodule

[rtl/dvaf_out_slice.sv]
// output register with skid word, ready towards the pipeline is registered
// no dependencies
module dvaf_out_slice #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  logic [DATA_W-1:0] up_data,
  output logic              up_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata
);
  logic              main_v_r;
  logic [DATA_W-1:0] main_d_r;
  logic              skid_v_r;
  logic [DATA_W-1:0] skid_d_r;

  assign up_ready   = !skid_v_r;
  assign out_tvalid = main_v_r;
  assign out_tdata  = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_tready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= up_valid;
      end
    end else if (up_valid && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_tready) begin
      main_d_r <= skid_v_r ? skid_d_r : up_data;
    end else if (up_valid && !skid_v_r) begin
      skid_d_r <= up_data;
    end
  end

endmodule

[rtl/dvaf_checker.sv]
// port-level checks for decal_vertex_alpha_fade, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module dvaf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_pready
);
  `AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `AST_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))
  `AST_NOW(a_ready_when_empty, !out_tvalid, in_tready)
  `AST_NOW(a_apb_ready, 1'b1, cfg_pready)
endmodule

bind decal_vertex_alpha_fade dvaf_checker u_dvaf_checker (.*);
